/* rtl/upd_pkg.sv */
`timescale 1ns / 1ps
// Shared types, character codes and helpers for the URL percent decoder.
// No dependencies; used by every module of the decoder.
package upd_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CHR_CR      = 8'h0D;
    localparam logic [7:0] CHR_PLUS    = 8'h2B;
    localparam logic [7:0] CHR_PERCENT = 8'h25;
    localparam logic [7:0] CHR_SPACE   = 8'h20;
    localparam logic [7:0] CHR_0       = 8'h30;
    localparam logic [7:0] CHR_9       = 8'h39;
    localparam logic [7:0] CHR_UA      = 8'h41;
    localparam logic [7:0] CHR_UF      = 8'h46;
    localparam logic [7:0] CHR_LA      = 8'h61;
    localparam logic [7:0] CHR_LF      = 8'h66;
    localparam logic [7:0] HEX_TEN     = 8'd10;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    // Hex digit lookup result.
    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_t;

    // One queue entry: the results caused by one input transfer.
    typedef struct packed {
        logic [7:0] byte0;
        logic       valid0;
        logic [7:0] byte1;
        logic       two;
        logic       last;
    } entry_t;

    function automatic hex_t hex_digit(input logic [7:0] b);
        hex_t       h;
        logic [7:0] d;
        d = 8'd0;
        h.is_hex = 1'b1;
        if (b >= CHR_0 && b <= CHR_9) begin
            d = b - CHR_0;
        end else if (b >= CHR_UA && b <= CHR_UF) begin
            d = b - CHR_UA + HEX_TEN;
        end else if (b >= CHR_LA && b <= CHR_LF) begin
            d = b - CHR_LA + HEX_TEN;
        end else begin
            h.is_hex = 1'b0;
        end
        h.value = d[3:0];
        return h;
    endfunction

    // A decoded escape value of zero or carriage return is dropped.
    function automatic logic keep_escape(input logic [7:0] v);
        return (v != 8'd0) && (v != CHR_CR);
    endfunction

endpackage

/* rtl/url_percent_decoder.sv */
`timescale 1ns / 1ps
// Top level of the URL percent decoder: front end, entry queue and back end.
// Depends on upd_pkg, upd_front, upd_queue and upd_back.
//
//   channel  direction  signals                                  handshake
//   s_       in         s_in_byte[7:0], s_in_last                s_valid / s_ready
//   m_       out        m_out_byte[7:0], m_out_valid, m_out_last m_valid / m_ready
//
// One input byte is taken per cycle while the queue has room. The transfer edge
// writes the queue entry, and the output register loads it from the queue head
// once that register is empty or its result is taken.
// The back end sends one result per cycle while m_ready is high, so a byte that
// causes two results holds its queue entry until both are loaded; the QUEUE_DEPTH entry queue absorbs this.
// Reset (aresetn low, synchronous) empties the queue and the output register.
// A stall on m_ready fills the queue and then drops s_ready.
module url_percent_decoder #(
    parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_valid,
    output logic       m_out_last
);

    upd_pkg::entry_t wr_entry, head;
    logic            push, pop, q_empty, q_full, accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    upd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_byte (s_in_byte),
        .in_last (s_in_last),
        .push    (push),
        .entry   (wr_entry)
    );

    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    upd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head),
        .empty       (q_empty),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_valid (m_out_valid),
        .m_out_last  (m_out_last)
    );

`ifndef NO_ASSERTIONS
    a_queue_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_empty && q_full))
        else $error("queue reports empty and full together");

    a_marker_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_out_valid) |-> m_out_last)
        else $error("end marker result without last flag");

    a_last_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_in_last) |=> !q_empty)
        else $error("final byte of a string left no queue entry");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_empty)
        else $error("back end popped an empty queue");
`endif

endmodule

/* rtl/upd_front.sv */
`timescale 1ns / 1ps
// Front end: tracks escape state and turns each input byte that yields a result or ends the string into a queue entry.
// Depends on upd_pkg.
module upd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output logic                push,
    output upd_pkg::entry_t     entry
);

    upd_pkg::phase_t phase_reg, phase_next;
    logic [3:0]      digit_reg, digit_next;

    upd_pkg::hex_t   h;
    logic            ordinary;
    logic            esc_v, ord_v, flush_v;
    logic [7:0]      esc_b, ord_b, flush_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= upd_pkg::PH_IDLE;
            digit_reg <= 4'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            digit_reg <= digit_next;
        end
    end

    always_comb begin
        h          = upd_pkg::hex_digit(in_byte);
        phase_next = upd_pkg::PH_IDLE;
        digit_next = digit_reg;
        ordinary   = 1'b1;
        esc_v      = 1'b0;
        esc_b      = {digit_reg, h.value};
        ord_v      = 1'b0;
        ord_b      = in_byte;
        flush_v    = 1'b0;
        flush_b    = 8'd0;

        unique case (phase_reg)
            upd_pkg::PH_PCT: begin
                if (h.is_hex) begin
                    digit_next = h.value;
                    phase_next = upd_pkg::PH_DIGIT;
                    ordinary   = 1'b0;
                end
            end
            upd_pkg::PH_DIGIT: begin
                if (h.is_hex) begin
                    ordinary = 1'b0;
                end else begin
                    esc_b = {4'd0, digit_reg};
                end
                esc_v = upd_pkg::keep_escape(esc_b);
            end
            default: begin
            end
        endcase

        if (ordinary) begin
            if (in_byte == upd_pkg::CHR_PLUS) begin
                ord_v = 1'b1;
                ord_b = upd_pkg::CHR_SPACE;
            end else if (in_byte == upd_pkg::CHR_PERCENT) begin
                phase_next = upd_pkg::PH_PCT;
                digit_next = 4'd0;
            end else if (in_byte != 8'd0) begin
                ord_v = 1'b1;
            end
        end

        // The end of the string closes a one-digit escape and resets the escape state.
        if (in_last) begin
            if (phase_next == upd_pkg::PH_DIGIT) begin
                flush_b = {4'd0, digit_next};
                flush_v = upd_pkg::keep_escape(flush_b);
            end
            phase_next = upd_pkg::PH_IDLE;
            digit_next = 4'd0;
        end

        entry.last  = in_last;
        entry.two   = (esc_v && (ord_v || flush_v)) || (ord_v && flush_v);
        entry.valid0 = esc_v || ord_v || flush_v;
        if (esc_v) begin
            entry.byte0 = esc_b;
            entry.byte1 = ord_v ? ord_b : flush_b;
        end else if (ord_v) begin
            entry.byte0 = ord_b;
            entry.byte1 = flush_b;
        end else begin
            entry.byte0 = flush_v ? flush_b : 8'd0;
            entry.byte1 = 8'd0;
        end

        push = accept && (entry.valid0 || in_last);
    end

endmodule

/* rtl/upd_queue.sv */
`timescale 1ns / 1ps
// Small register FIFO of decoded entries between the front and back ends.
// Depends on upd_pkg.
module upd_queue #(
    parameter int DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  upd_pkg::entry_t wr_entry,
    input  logic            pop,
    output upd_pkg::entry_t head,
    output logic            empty,
    output logic            full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    upd_pkg::entry_t mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    assign head  = mem[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(DEPTH));

endmodule

/* rtl/upd_back.sv */
`timescale 1ns / 1ps
// Back end: expands each queue entry into one or two results in an output register.
// Depends on upd_pkg.
module upd_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  upd_pkg::entry_t head,
    input  logic            empty,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_out_valid,
    output logic            m_out_last
);

    logic       valid_reg, valid_next;
    logic       second_reg, second_next;
    logic [7:0] byte_reg, byte_next;
    logic       bvalid_reg, bvalid_next;
    logic       last_reg, last_next;
    logic       load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        bvalid_reg <= bvalid_next;
        last_reg   <= last_next;
    end

    always_comb begin
        load        = !empty && (!valid_reg || m_ready);
        valid_next  = load ? 1'b1 : (valid_reg && !m_ready);
        second_next = second_reg;
        byte_next   = byte_reg;
        bvalid_next = bvalid_reg;
        last_next   = last_reg;
        pop         = 1'b0;
        if (load) begin
            if (second_reg) begin
                byte_next   = head.byte1;
                bvalid_next = 1'b1;
                last_next   = head.last;
                second_next = 1'b0;
                pop         = 1'b1;
            end else if (head.two) begin
                // Hold the entry; its second result goes out on the next load.
                byte_next   = head.byte0;
                bvalid_next = 1'b1;
                last_next   = 1'b0;
                second_next = 1'b1;
            end else begin
                byte_next   = head.byte0;
                bvalid_next = head.valid0;
                last_next   = head.last;
                pop         = 1'b1;
            end
        end
    end

    assign m_valid     = valid_reg;
    assign m_out_byte  = byte_reg;
    assign m_out_valid = bvalid_reg;
    assign m_out_last  = last_reg;

endmodule
